[rtl/cdq_pkg.sv]
// Shared types and codes for the circular deque unit.
package cdq_pkg;

    localparam int unsigned REQ_W = 3;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned ST_W  = 2;

    // Request codes as they arrive on the input
    typedef enum logic [REQ_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_LIST       = 3'd4
    } t_op;

    // Result status codes
    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_UNDER = 2'd2
    } t_status;

    // Back-end sequencer states
    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    // Classified request word, front to back
    typedef struct packed {
        t_op                     op;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    // Result word, back to output queue
    typedef struct packed {
        t_status                 status;
        logic signed [VAL_W-1:0] value;
        logic                    last;
    } t_res;

endpackage

[rtl/cdq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/cdq_fifo.sv]
// Small register-based FIFO used between the deque stages.
module cdq_fifo #(
    parameter int unsigned WIDTH = 35,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int unsigned IW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [IW-1:0]    r_wp, n_wp;
    logic [IW-1:0]    r_rp, n_rp;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             wr_ok;
    logic             rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_ok   = i_push && !o_full;
    assign rd_ok   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    // Pointer and count update
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wp = (r_wp == IW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
        end
        if (rd_ok) begin
            n_rp = (r_rp == IW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + 1'b1;
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

[rtl/cdq_front.sv]
// Front end: accepts requests, drops unused codes, queues commands.
module cdq_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [cdq_pkg::REQ_W-1:0]           i_req_type,
    input  logic signed [cdq_pkg::VAL_W-1:0]    i_push_value,
    output logic                                o_cmd_valid,
    output cdq_pkg::t_cmd                       o_cmd,
    input  logic                                i_cmd_pop
);
    import cdq_pkg::*;

    logic [$bits(t_cmd)-1:0] q_data;
    logic                    q_empty;
    logic                    code_ok;
    t_cmd                    cmd_in;

    // Classify request code
    always_comb begin
        unique case (i_req_type) inside
            OP_PUSH_FRONT, OP_PUSH_REAR, OP_POP_FRONT, OP_POP_REAR, OP_LIST: code_ok = 1'b1;
            default: code_ok = 1'b0;
        endcase
    end

    assign cmd_in.op    = t_op'(i_req_type);
    assign cmd_in.value = i_push_value;

    // Command queue; unused codes are accepted and dropped
    cdq_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (2)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push && code_ok),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (i_cmd_pop),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign o_cmd_valid = !q_empty;
    assign o_cmd       = t_cmd'(q_data);

endmodule

[rtl/cdq_back.sv]
// Back end: deque indices, word store and result sequencer.
module cdq_back #(
    parameter int unsigned DEPTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  cdq_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic          i_res_full,
    output logic          o_res_push,
    output cdq_pkg::t_res o_res
);
    import cdq_pkg::*;

    localparam int unsigned AW = $clog2(DEPTH);

    t_state           r_state, n_state;
    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic             r_empty, n_empty;
    logic [AW-1:0]    r_ptr, n_ptr;
    logic             r_list, n_list;

    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    logic [VAL_W-1:0] rd_data;
    logic             dq_full;
    logic             emit_last;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    function automatic logic [AW-1:0] wrap_dec(input logic [AW-1:0] idx);
        return (idx == '0) ? AW'(DEPTH - 1) : idx - 1'b1;
    endfunction

    assign dq_full   = !r_empty && (wrap_inc(r_tail) == r_head);
    assign emit_last = !r_list || (r_ptr == r_tail);

    // Sequencer: next state, index updates, store access, result
    always_comb begin
        n_state      = r_state;
        n_head       = r_head;
        n_tail       = r_tail;
        n_empty      = r_empty;
        n_ptr        = r_ptr;
        n_list       = r_list;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res.status = ST_OK;
        o_res.value  = '0;
        o_res.last   = 1'b1;
        wr_en        = 1'b0;
        wr_addr      = '0;
        rd_en        = 1'b0;
        rd_addr      = r_ptr;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    case (i_cmd.op) inside
                        OP_PUSH_FRONT, OP_PUSH_REAR: begin
                            o_res_push = 1'b1;
                            if (dq_full) begin
                                o_res.status = ST_OVER;
                            end else begin
                                wr_en   = 1'b1;
                                n_empty = 1'b0;
                                if (r_empty) begin
                                    n_head  = '0;
                                    n_tail  = '0;
                                    wr_addr = '0;
                                end else if (i_cmd.op == OP_PUSH_FRONT) begin
                                    n_head  = wrap_dec(r_head);
                                    wr_addr = wrap_dec(r_head);
                                end else begin
                                    n_tail  = wrap_inc(r_tail);
                                    wr_addr = wrap_inc(r_tail);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR: begin
                            if (r_empty) begin
                                o_res_push   = 1'b1;
                                o_res.status = ST_UNDER;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = (i_cmd.op == OP_POP_FRONT) ? r_head : r_tail;
                                n_list  = 1'b0;
                                n_state = S_EMIT;
                                if (r_head == r_tail) begin
                                    n_empty = 1'b1;
                                    n_head  = '0;
                                    n_tail  = '0;
                                end else if (i_cmd.op == OP_POP_FRONT) begin
                                    n_head = wrap_inc(r_head);
                                end else begin
                                    n_tail = wrap_dec(r_tail);
                                end
                            end
                        end
                        default: begin
                            // list contents
                            if (r_empty) begin
                                o_res_push   = 1'b1;
                                o_res.status = ST_UNDER;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_ptr   = r_head;
                                n_list  = 1'b1;
                                n_state = S_EMIT;
                            end
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push  = 1'b1;
                    o_res.value = rd_data;
                    o_res.last  = emit_last;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_ptr   = wrap_inc(r_ptr);
                        rd_en   = 1'b1;
                        rd_addr = wrap_inc(r_ptr);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_empty <= 1'b1;
            r_ptr   <= '0;
            r_list  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_empty <= n_empty;
            r_ptr   <= n_ptr;
            r_list  <= n_list;
        end
    end

    // Word store
    cdq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_cmd.value),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule

[rtl/circular_deque_unit.sv]
// Circular deque unit: front queue, deque engine and result queue.
// A push result goes from the idle state straight into the result queue; a pop result
// or list word first passes the registered read of the word store and the emit state.
// The engine takes no new command while it emits a pop result or list words, and it
// stalls while the result queue is full; the engine sequencer and the store read set this.
// Reset clears indices, empty flag and both queues; the store is not cleared.
module circular_deque_unit #(
    parameter int unsigned DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic [cdq_pkg::REQ_W-1:0]        i_req_type,
    input  logic signed [cdq_pkg::VAL_W-1:0] i_push_value,
    output logic                             empty,
    input  logic                             pop,
    output logic [cdq_pkg::ST_W-1:0]         o_status,
    output logic signed [cdq_pkg::VAL_W-1:0] o_item_value,
    output logic                             o_last_item
);
    import cdq_pkg::*;

    logic                    cmd_valid;
    t_cmd                    cmd;
    logic                    cmd_pop;
    logic                    res_full;
    logic                    res_push;
    t_res                    res;
    logic [$bits(t_res)-1:0] res_q_data;
    t_res                    res_out;

    // Request intake
    cdq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd),
        .i_cmd_pop    (cmd_pop)
    );

    // Deque engine
    cdq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Result queue
    cdq_fifo #(
        .WIDTH ($bits(t_res)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q_data),
        .o_empty (empty)
    );

    assign res_out      = t_res'(res_q_data);
    assign o_status     = res_out.status;
    assign o_item_value = res_out.value;
    assign o_last_item  = res_out.last;

    // Engine never writes a full result queue
    a_no_res_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_push |-> !res_full)
        else $error("result written into full queue");

    // Only list words may be non-final, and they are always ok
    a_mid_list_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res_push && !res.last) |-> (res.status == ST_OK))
        else $error("non-final result with error status");

    // Nothing waits on the output right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // A command is taken only when one is offered
    a_cmd_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

endmodule
